[hdl/snta_pkg.sv]
// ----------------------------------------------------------------------------
// snta_pkg: shared types and constants of the seconds/nanoseconds time ALU
// Request codes, unit codes for tick conversion, divisor reciprocals and the
// record that travels down the pipeline with every beat.
// ----------------------------------------------------------------------------
`default_nettype none

package snta_pkg;

  // Field widths
  localparam int unsigned SEC_W   = 64;
  localparam int unsigned RAW_W   = 64;
  localparam int unsigned ANS_W   = 32;
  localparam int unsigned NS_W    = 30;
  localparam int unsigned REQ_W   = 3;

  // Division by a unit constant: dividend width, its halves, remainder width
  localparam int unsigned WORD_W  = RAW_W;
  localparam int unsigned HALF_W  = WORD_W / 2;
  localparam int unsigned REM_W   = NS_W;

  // Time constants
  localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [NS_W-1:0] NS_PER_MS  = 30'd1000000;
  localparam logic [NS_W-1:0] NS_PER_US  = 30'd1000;
  localparam logic [NS_W-1:0] MS_PER_SEC = 30'd1000;
  localparam logic [NS_W-1:0] US_PER_SEC = 30'd1000000;

  // Reciprocals floor(2^64 / divisor); the estimate is low by at most one
  localparam logic [WORD_W-1:0] RECIP_MS = 64'd18446744073709551;
  localparam logic [WORD_W-1:0] RECIP_US = 64'd18446744073709;
  localparam logic [WORD_W-1:0] RECIP_NS = 64'd18446744073;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    OP_FROM_SEC = 3'd0,
    OP_FROM_MS  = 3'd1,
    OP_FROM_US  = 3'd2,
    OP_FROM_NS  = 3'd3,
    OP_ADD      = 3'd4,
    OP_SUB      = 3'd5,
    OP_CMP      = 3'd6
  } op_e;

  // Tick unit: selects the divisor and the remainder scale
  typedef enum logic [1:0] {
    UNIT_MS = 2'd0,
    UNIT_US = 2'd1,
    UNIT_NS = 2'd2
  } unit_e;

  // Record carried through the divider stages
  typedef struct packed {
    unit_e              unit;
    logic [REM_W-1:0]   rem;
    logic [WORD_W-1:0]  word;
    logic [SEC_W-1:0]   base;
    logic               eq;
    logic               gt;
    logic               lt;
    logic               inf;
  } stage_t;

  // Divisor for a tick unit
  function automatic logic [REM_W-1:0] divisor(unit_e unit);
    logic [REM_W-1:0] dvs;
    case (unit)
      UNIT_MS: dvs = MS_PER_SEC;
      UNIT_US: dvs = US_PER_SEC;
      UNIT_NS: dvs = NS_PER_SEC;
      default: dvs = NS_PER_SEC;
    endcase
    return dvs;
  endfunction

  // Reciprocal of the divisor for a tick unit
  function automatic logic [WORD_W-1:0] reciprocal(unit_e unit);
    logic [WORD_W-1:0] rcp;
    case (unit)
      UNIT_MS: rcp = RECIP_MS;
      UNIT_US: rcp = RECIP_US;
      UNIT_NS: rcp = RECIP_NS;
      default: rcp = RECIP_NS;
    endcase
    return rcp;
  endfunction

endpackage

`default_nettype wire

[hdl/snta_if.sv]
// ----------------------------------------------------------------------------
// snta_if: request and result channels of the time ALU
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface snta_req_if;
  logic                             valid;
  logic                             ready;
  logic [snta_pkg::REQ_W-1:0]       req_type;
  logic [snta_pkg::RAW_W-1:0]       raw_count;
  logic signed [snta_pkg::SEC_W-1:0] a_seconds;
  logic [snta_pkg::ANS_W-1:0]       a_nanos;
  logic signed [snta_pkg::SEC_W-1:0] b_seconds;
  logic [snta_pkg::NS_W-1:0]        b_nanos;

  modport source (
    output valid, req_type, raw_count, a_seconds, a_nanos, b_seconds, b_nanos,
    input  ready
  );
  modport sink (
    input  valid, req_type, raw_count, a_seconds, a_nanos, b_seconds, b_nanos,
    output ready
  );
endinterface

interface snta_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [snta_pkg::SEC_W-1:0] res_seconds;
  logic [snta_pkg::NS_W-1:0]        res_nanos;
  logic                             is_equal;
  logic                             is_greater;
  logic                             is_less;
  logic                             left_infinite;

  modport source (
    output valid, res_seconds, res_nanos, is_equal, is_greater, is_less,
           left_infinite,
    input  ready
  );
  modport sink (
    input  valid, res_seconds, res_nanos, is_equal, is_greater, is_less,
           left_infinite,
    output ready
  );
endinterface

`default_nettype wire

[hdl/snta_front.sv]
// ----------------------------------------------------------------------------
// snta_front: request decode stage
// Builds the dividend, the seconds base and the compare flags of a request
// and registers them as the first pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module snta_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  snta_req_if.sink             req_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output snta_pkg::stage_t     out_data_o
);

  snta_pkg::op_e                op;
  snta_pkg::stage_t             data_d;
  snta_pkg::stage_t             data_q;
  logic                         valid_q;
  logic [snta_pkg::NS_W+3:0]    add_ns;
  logic [snta_pkg::NS_W+3:0]    sub_ns;
  logic                         sec_eq;
  logic                         sec_gt;
  logic                         ns_eq;
  logic                         ns_gt;

  assign op = snta_pkg::op_e'(req_i.req_type);

  // Nanosecond sum and biased difference (two seconds added keep it positive)
  assign add_ns = (snta_pkg::NS_W+4)'(req_i.a_nanos) + (snta_pkg::NS_W+4)'(req_i.b_nanos);
  assign sub_ns = (snta_pkg::NS_W+4)'(req_i.a_nanos)
                + ((snta_pkg::NS_W+4)'(snta_pkg::NS_PER_SEC) << 1)
                - (snta_pkg::NS_W+4)'(req_i.b_nanos);

  // Signed seconds, then raw nanos
  assign sec_eq = (req_i.a_seconds == req_i.b_seconds);
  assign sec_gt = (req_i.a_seconds > req_i.b_seconds);
  assign ns_eq  = (req_i.a_nanos == snta_pkg::ANS_W'(req_i.b_nanos));
  assign ns_gt  = (req_i.a_nanos >  snta_pkg::ANS_W'(req_i.b_nanos));

  // Decode the request into divider operands
  always_comb begin
    data_d      = '0;
    data_d.unit = snta_pkg::UNIT_NS;
    data_d.inf  = &req_i.a_nanos;
    case (op)
      snta_pkg::OP_FROM_SEC: begin
        data_d.base = req_i.a_seconds;
      end
      snta_pkg::OP_FROM_MS: begin
        data_d.unit = snta_pkg::UNIT_MS;
        data_d.word = req_i.raw_count;
      end
      snta_pkg::OP_FROM_US: begin
        data_d.unit = snta_pkg::UNIT_US;
        data_d.word = req_i.raw_count;
      end
      snta_pkg::OP_FROM_NS: begin
        data_d.word = req_i.raw_count;
      end
      snta_pkg::OP_ADD: begin
        data_d.word = snta_pkg::WORD_W'(add_ns);
        data_d.base = req_i.a_seconds + req_i.b_seconds;
      end
      snta_pkg::OP_SUB: begin
        data_d.word = snta_pkg::WORD_W'(sub_ns);
        data_d.base = req_i.a_seconds - req_i.b_seconds - snta_pkg::SEC_W'(2);
      end
      snta_pkg::OP_CMP: begin
        data_d.eq = sec_eq & ns_eq;
        data_d.gt = sec_gt | (sec_eq & ns_gt);
        data_d.lt = ~sec_gt & ~sec_eq | (sec_eq & ~ns_gt & ~ns_eq);
      end
      default: begin
      end
    endcase
  end

  assign req_i.ready = ~valid_q | out_ready_i;

  // Hold the beat until the next stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

[hdl/snta_div_stage.sv]
// ----------------------------------------------------------------------------
// snta_div_stage: divider by the tick-unit constant
// Multiplies the dividend by a fixed-point reciprocal in 32-bit halves, then
// corrects the quotient estimate with one compare and subtract. Four
// register stages, each able to stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module snta_div_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire snta_pkg::stage_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output snta_pkg::stage_t       out_data_o
);

  logic [snta_pkg::HALF_W-1:0]   x_hi;
  logic [snta_pkg::HALF_W-1:0]   x_lo;
  logic [snta_pkg::HALF_W-1:0]   r_hi;
  logic [snta_pkg::HALF_W-1:0]   r_lo;
  logic [snta_pkg::WORD_W-1:0]   pp_hh_d;
  logic [snta_pkg::WORD_W-1:0]   pp_hl_d;
  logic [snta_pkg::WORD_W-1:0]   pp_lh_d;
  logic [snta_pkg::WORD_W-1:0]   pp_ll_d;
  logic [snta_pkg::WORD_W-1:0]   pp_hh_q;
  logic [snta_pkg::WORD_W-1:0]   pp_hl_q;
  logic [snta_pkg::WORD_W-1:0]   pp_lh_q;
  logic [snta_pkg::WORD_W-1:0]   pp_ll_q;
  snta_pkg::stage_t              a_data_q;
  logic                          a_valid_q;
  logic [snta_pkg::WORD_W+1:0]   mid;
  logic [snta_pkg::WORD_W-1:0]   quot_b_d;
  logic [snta_pkg::WORD_W-1:0]   quot_b_q;
  snta_pkg::stage_t              b_data_q;
  logic                          b_valid_q;
  logic                          b_ready;
  logic [snta_pkg::HALF_W-1:0]   low_c_d;
  logic [snta_pkg::HALF_W-1:0]   low_c_q;
  logic [snta_pkg::WORD_W-1:0]   quot_c_q;
  snta_pkg::stage_t              c_data_q;
  logic                          c_valid_q;
  logic                          c_ready;
  logic [snta_pkg::REM_W-1:0]    dvs;
  logic [snta_pkg::HALF_W-1:0]   part;
  logic                          take;
  snta_pkg::stage_t              data_d;
  snta_pkg::stage_t              data_q;
  logic                          valid_q;
  logic                          d_ready;

  // Split dividend and reciprocal into halves, form the four products
  assign {x_hi, x_lo} = in_data_i.word;
  assign {r_hi, r_lo} = snta_pkg::reciprocal(in_data_i.unit);
  assign pp_hh_d = snta_pkg::WORD_W'(x_hi) * snta_pkg::WORD_W'(r_hi);
  assign pp_hl_d = snta_pkg::WORD_W'(x_hi) * snta_pkg::WORD_W'(r_lo);
  assign pp_lh_d = snta_pkg::WORD_W'(x_lo) * snta_pkg::WORD_W'(r_hi);
  assign pp_ll_d = snta_pkg::WORD_W'(x_lo) * snta_pkg::WORD_W'(r_lo);

  assign in_ready_o = ~a_valid_q | b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_data_q <= in_data_i;
      pp_hh_q  <= pp_hh_d;
      pp_hl_q  <= pp_hl_d;
      pp_lh_q  <= pp_lh_d;
      pp_ll_q  <= pp_ll_d;
    end
  end

  // Sum the products: upper word of the full product is the estimate
  assign mid      = (snta_pkg::WORD_W+2)'(pp_hl_q) + (snta_pkg::WORD_W+2)'(pp_lh_q)
                  + (snta_pkg::WORD_W+2)'(pp_ll_q[snta_pkg::WORD_W-1:snta_pkg::HALF_W]);
  assign quot_b_d = pp_hh_q + snta_pkg::WORD_W'(mid[snta_pkg::WORD_W+1:snta_pkg::HALF_W]);

  assign b_ready = ~b_valid_q | c_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) begin
      b_data_q <= a_data_q;
      quot_b_q <= quot_b_d;
    end
  end

  // Low half of estimate times divisor; the remainder fits in it
  assign low_c_d = quot_b_q[snta_pkg::HALF_W-1:0]
                 * snta_pkg::HALF_W'(snta_pkg::divisor(b_data_q.unit));

  assign c_ready = ~c_valid_q | d_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q && c_ready) begin
      c_data_q <= b_data_q;
      quot_c_q <= quot_b_q;
      low_c_q  <= low_c_d;
    end
  end

  // Correct an estimate that is one low, hand quotient and remainder on
  assign dvs  = snta_pkg::divisor(c_data_q.unit);
  assign part = c_data_q.word[snta_pkg::HALF_W-1:0] - low_c_q;
  assign take = (part >= snta_pkg::HALF_W'(dvs));

  always_comb begin
    data_d      = c_data_q;
    data_d.word = quot_c_q + snta_pkg::WORD_W'(take);
    data_d.rem  = take ? snta_pkg::REM_W'(part - snta_pkg::HALF_W'(dvs))
                       : snta_pkg::REM_W'(part);
  end

  assign d_ready = ~valid_q | out_ready_i;

  // Advance when the next stage has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (d_ready) begin
      valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid_q && d_ready) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

[hdl/snta_back.sv]
// ----------------------------------------------------------------------------
// snta_back: result assembly and output register
// Adds the quotient to the seconds base, scales the remainder to nanos
// and holds the finished beat for the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module snta_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire snta_pkg::stage_t  in_data_i,
  snta_res_if.source             res_o
);

  logic                            valid_q;
  logic [snta_pkg::SEC_W-1:0]      sec_d;
  logic [snta_pkg::SEC_W-1:0]      sec_q;
  logic [snta_pkg::NS_W-1:0]       ns_d;
  logic [snta_pkg::NS_W-1:0]       ns_q;
  logic [3:0]                      flags_q;

  // Seconds: base plus quotient; zero base and dividend where unused
  assign sec_d = in_data_i.base + in_data_i.word;

  // Scale the remainder of a tick conversion to nanoseconds
  always_comb begin
    case (in_data_i.unit)
      snta_pkg::UNIT_MS: ns_d = in_data_i.rem * snta_pkg::NS_PER_MS;
      snta_pkg::UNIT_US: ns_d = in_data_i.rem * snta_pkg::NS_PER_US;
      snta_pkg::UNIT_NS: ns_d = in_data_i.rem;
      default:           ns_d = in_data_i.rem;
    endcase
  end

  assign in_ready_o = ~valid_q | res_o.ready;

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sec_q   <= sec_d;
      ns_q    <= ns_d;
      flags_q <= {in_data_i.eq, in_data_i.gt, in_data_i.lt, in_data_i.inf};
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.res_seconds   = sec_q;
  assign res_o.res_nanos     = ns_q;
  assign res_o.is_equal      = flags_q[3];
  assign res_o.is_greater    = flags_q[2];
  assign res_o.is_less       = flags_q[1];
  assign res_o.left_infinite = flags_q[0];

endmodule

`default_nettype wire

[hdl/seconds_nanos_time_alu.sv]
// ----------------------------------------------------------------------------
// seconds_nanos_time_alu: seconds/nanoseconds conversion, add/sub, compare
// Pipeline: an accepted request passes the decode register, four divider
//   stages (reciprocal products, product sum, estimate times divisor,
//   remainder correction) and then the result register.
// Throughput: one request per cycle while results are taken; each stage
//   stalls alone, so bubbles close up while a result waits on the output.
// Reset: clears the valid bit of every stage; no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module seconds_nanos_time_alu (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  snta_req_if.sink   req_i,
  snta_res_if.source res_o
);

  snta_pkg::stage_t  front_data;
  snta_pkg::stage_t  div_data;
  logic              front_valid;
  logic              front_ready;
  logic              div_valid;
  logic              div_ready;

  // Decode and register the request
  snta_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_data_o  (front_data)
  );

  // Divide by the unit constant
  snta_div_stage u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_data_i   (front_data),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_data_o  (div_data)
  );

  // Assemble and hold the result
  snta_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (div_valid),
    .in_ready_o (div_ready),
    .in_data_i  (div_data),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the seconds/nanoseconds time ALU
// Walks a directed table of edge cases (extremes, carry and borrow, seconds
// wrap, the infinite marker, every compare outcome, the undefined request
// code), then random requests. Each accepted request queues its expected
// result, typed in or predicted; each result beat is checked field by field
// against the oldest one. Both channels idle at random, with calm stretches.
// ----------------------------------------------------------------------------
module tb;
  import snta_pkg::*;

  localparam int unsigned CLK_HALF    = 5;
  localparam int unsigned RST_CYCLES  = 12;
  localparam int unsigned LATENCY     = 6;
  localparam int unsigned RAND_ITEMS  = 550;
  localparam int unsigned CYCLE_LIMIT = 300000;

  // Request code left undefined by the package
  localparam logic [REQ_W-1:0] OP_UNDEF = 3'd7;

  localparam logic [63:0]      SEC_MAX     = {1'b0, {63{1'b1}}};
  localparam logic [63:0]      SEC_MIN     = {1'b1, 63'd0};
  localparam logic [ANS_W-1:0] NANOS_INF   = '1;
  localparam logic [NS_W-1:0]  NS_TOP      = NS_PER_SEC - 1'b1;
  localparam logic [63:0]      NS_SEC64    = 64'(NS_PER_SEC);
  localparam logic [63:0]      NS_MS64     = 64'(NS_PER_MS);
  localparam logic [63:0]      NS_US64     = 64'(NS_PER_US);
  localparam logic [63:0]      MS_SEC64    = 64'(MS_PER_SEC);
  localparam logic [63:0]      US_SEC64    = 64'(US_PER_SEC);
  // Whole seconds lent to the nanos difference so it never goes negative
  localparam logic [63:0]      BORROW_SECS = 64'd2;

  typedef struct packed {
    logic [REQ_W-1:0] op;
    logic [RAW_W-1:0] raw;
    logic [SEC_W-1:0] a_sec;
    logic [ANS_W-1:0] a_ns;
    logic [SEC_W-1:0] b_sec;
    logic [NS_W-1:0]  b_ns;
  } time_req_t;

  typedef struct packed {
    logic [SEC_W-1:0] sec;
    logic [NS_W-1:0]  ns;
    logic             eq;
    logic             gt;
    logic             lt;
    logic             inf;
  } time_res_t;

  logic clk = 1'b0;
  logic rst_n;

  snta_req_if req_if ();
  snta_res_if res_if ();

  seconds_nanos_time_alu dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  time_res_t   pending_times[$];
  time_req_t   edge_reqs[$];
  time_res_t   edge_results[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  always #(CLK_HALF) clk = ~clk;

  // Compute the result beat that a request must produce
  function automatic time_res_t predict_time(time_req_t r);
    time_res_t   o;
    logic [63:0] t;
    o = '0;
    case (r.op)
      OP_FROM_SEC: o.sec = r.a_sec;
      OP_FROM_MS: begin
        o.sec = r.raw / MS_SEC64;
        o.ns  = NS_W'((r.raw % MS_SEC64) * NS_MS64);
      end
      OP_FROM_US: begin
        o.sec = r.raw / US_SEC64;
        o.ns  = NS_W'((r.raw % US_SEC64) * NS_US64);
      end
      OP_FROM_NS: begin
        o.sec = r.raw / NS_SEC64;
        o.ns  = NS_W'(r.raw % NS_SEC64);
      end
      OP_ADD: begin
        t     = 64'(r.a_ns) + 64'(r.b_ns);
        o.sec = r.a_sec + r.b_sec + t / NS_SEC64;
        o.ns  = NS_W'(t % NS_SEC64);
      end
      OP_SUB: begin
        t     = 64'(r.a_ns) + BORROW_SECS * NS_SEC64 - 64'(r.b_ns);
        o.sec = r.a_sec - r.b_sec + t / NS_SEC64 - BORROW_SECS;
        o.ns  = NS_W'(t % NS_SEC64);
      end
      OP_CMP: begin
        // Signed seconds first, then raw nanos as unsigned
        if (r.a_sec == r.b_sec) begin
          o.eq = (r.a_ns == ANS_W'(r.b_ns));
          o.gt = (r.a_ns >  ANS_W'(r.b_ns));
          o.lt = (r.a_ns <  ANS_W'(r.b_ns));
        end else begin
          o.gt = ($signed(r.a_sec) > $signed(r.b_sec));
          o.lt = ($signed(r.a_sec) < $signed(r.b_sec));
        end
      end
      default: ;
    endcase
    o.inf = (r.a_ns == NANOS_INF);
    return o;
  endfunction

  // Table row checked against the predictor
  function automatic void vec(logic [REQ_W-1:0] op, logic [63:0] raw, logic [63:0] as,
                              logic [ANS_W-1:0] an, logic [63:0] bs, logic [NS_W-1:0] bn);
    time_req_t r;
    r = '{op: op, raw: raw, a_sec: as, a_ns: an, b_sec: bs, b_ns: bn};
    edge_reqs.push_back(r);
    edge_results.push_back(predict_time(r));
  endfunction

  // Table row with its result typed in; flags are {eq, gt, lt, inf}
  function automatic void vec_exp(logic [REQ_W-1:0] op, logic [63:0] raw, logic [63:0] as,
                                  logic [ANS_W-1:0] an, logic [63:0] bs, logic [NS_W-1:0] bn,
                                  logic [63:0] rs, logic [NS_W-1:0] rn, logic [3:0] flags);
    time_res_t e;
    edge_reqs.push_back('{op: op, raw: raw, a_sec: as, a_ns: an, b_sec: bs, b_ns: bn});
    e.sec = rs;
    e.ns  = rn;
    e.eq  = flags[3];
    e.gt  = flags[2];
    e.lt  = flags[1];
    e.inf = flags[0];
    edge_results.push_back(e);
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(bit calm);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (calm || p < 45) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Wide operand biased toward the extremes
  function automatic logic [63:0] rand_wide();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return SEC_MAX;
      3: return SEC_MIN;
      4: return 64'($urandom_range(0, 100000));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Idle for gap cycles, then hold the request until a beat moves
  task automatic send_req(time_req_t r, time_res_t e, int unsigned gap);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.req_type  <= r.op;
    req_if.raw_count <= r.raw;
    req_if.a_seconds <= r.a_sec;
    req_if.a_nanos   <= r.a_ns;
    req_if.b_seconds <= r.b_sec;
    req_if.b_nanos   <= r.b_ns;
    req_if.valid     <= 1'b1;
    do @(posedge clk); while (!req_if.ready);
    pending_times.push_back(e);
  endtask

  // Stimulus: reset, directed table, random requests, drain
  initial begin : stim
    time_req_t r;
    bit        calm;
    rst_n            <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.req_type  <= '0;
    req_if.raw_count <= '0;
    req_if.a_seconds <= '0;
    req_if.a_nanos   <= '0;
    req_if.b_seconds <= '0;
    req_if.b_nanos   <= '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Conversions at the extremes of seconds and tick counts
    vec_exp(OP_FROM_SEC, '0, SEC_MAX, '0, 64'd9, NS_TOP, SEC_MAX, '0, 4'b0000);
    vec_exp(OP_FROM_SEC, '1, SEC_MIN, NANOS_INF, '1, NS_TOP, SEC_MIN, '0, 4'b0001);
    vec_exp(OP_FROM_MS, '0, '1, '0, '1, '0, '0, '0, 4'b0000);
    vec(OP_FROM_MS, '1, '0, 32'd5, '0, '0);
    vec(OP_FROM_US, '1, '0, '0, '0, '0);
    vec(OP_FROM_NS, '1, '0, '0, '0, '0);
    vec_exp(OP_FROM_NS, 64'(NS_TOP), '0, '0, '0, '0, '0, NS_TOP, 4'b0000);
    vec_exp(OP_FROM_NS, NS_SEC64, '0, '0, '0, '0, 64'd1, '0, 4'b0000);
    // Add: carry, seconds wrap, infinite marker taken as a number
    vec_exp(OP_ADD, '0, '0, 32'(NS_TOP), '0, 30'd1, 64'd1, '0, 4'b0000);
    vec_exp(OP_ADD, '0, SEC_MAX, 32'(NS_TOP), '0, 30'd1, SEC_MIN, '0, 4'b0000);
    vec(OP_ADD, '0, '0, NANOS_INF, '0, NS_TOP);
    vec(OP_ADD, '0, 64'd123456789, 32'd400000000, '1, 30'd700000000);
    // Subtract: borrow, seconds wrap, unnormalized nanos
    vec_exp(OP_SUB, '0, 64'd1, '0, '0, 30'd1, '0, NS_TOP, 4'b0000);
    vec_exp(OP_SUB, '0, SEC_MIN, '0, 64'd1, '0, SEC_MAX, '0, 4'b0000);
    vec(OP_SUB, '0, '0, NANOS_INF, SEC_MAX, '0);
    vec(OP_SUB, '0, SEC_MAX, 32'hFFFF_FFFE, SEC_MIN, NS_TOP);
    // Compare: every outcome, signed seconds, raw nanos
    vec_exp(OP_CMP, '1, 64'd5, 32'd7, 64'd5, 30'd7, '0, '0, 4'b1000);
    vec_exp(OP_CMP, '0, SEC_MAX, '0, SEC_MIN, NS_TOP, '0, '0, 4'b0100);
    vec_exp(OP_CMP, '0, '1, '0, '0, '0, '0, '0, 4'b0010);
    vec_exp(OP_CMP, '0, 64'd3, NANOS_INF, 64'd3, NS_TOP, '0, '0, 4'b0101);
    vec_exp(OP_CMP, '0, 64'd3, '0, 64'd3, 30'd1, '0, '0, 4'b0010);
    // Undefined request code: all zero but the infinite flag
    vec_exp(OP_UNDEF, '1, SEC_MAX, NANOS_INF, SEC_MAX, NS_TOP, '0, '0, 4'b0001);
    vec_exp(OP_UNDEF, '1, 64'd77, 32'd12, 64'd77, 30'd12, '0, '0, 4'b0000);

    foreach (edge_reqs[i]) send_req(edge_reqs[i], edge_results[i], pick_gap(1'b0));

    calm = 1'b0;
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      // Switch between idling and back-to-back stretches
      if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      r.op    = REQ_W'($urandom_range(0, 7));
      r.raw   = rand_wide();
      r.a_sec = rand_wide();
      r.b_sec = rand_wide();
      case ($urandom_range(0, 9))
        0: r.a_ns = NANOS_INF;
        1: r.a_ns = $urandom();
        2: r.a_ns = 32'(NS_TOP);
        default: r.a_ns = $urandom_range(0, 32'(NS_TOP));
      endcase
      r.b_ns = ($urandom_range(0, 9) == 0) ? NS_TOP : NS_W'($urandom_range(0, 32'(NS_TOP)));
      // Tie the seconds often so compares reach the nanos path
      if ($urandom_range(0, 2) == 0) r.b_sec = r.a_sec;
      if ($urandom_range(0, 7) == 0 && r.a_ns <= 32'(NS_TOP)) r.b_ns = r.a_ns[NS_W-1:0];
      send_req(r, predict_time(r), pick_gap(calm));
    end
    req_if.valid <= 1'b0;

    while (pending_times.size() != 0) @(posedge clk);
    repeat (3 * LATENCY) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[seconds_nanos_time_alu] OK");
    end else begin
      $display("[seconds_nanos_time_alu] ERROR");
    end
    $finish;
  end

  // Result side: long ready stretches, stalls of random length
  initial begin : res_drain
    int unsigned hold;
    int unsigned stall;
    res_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      hold = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
      res_if.ready <= 1'b1;
      repeat (hold) @(posedge clk);
      stall = pick_gap(1'b0);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin : res_check
    time_res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_times.size() == 0) begin
        $error("result beat with no request pending");
        mismatch_cnt++;
      end else begin
        want = pending_times.pop_front();
        if (res_if.res_seconds !== want.sec) begin
          $error("res_seconds: expected %0d, got %0d", $signed(want.sec),
                 $signed(res_if.res_seconds));
          mismatch_cnt++;
        end
        if (res_if.res_nanos !== want.ns) begin
          $error("res_nanos: expected %0d, got %0d", want.ns, res_if.res_nanos);
          mismatch_cnt++;
        end
        if (res_if.is_equal !== want.eq) begin
          $error("is_equal: expected %0b, got %0b", want.eq, res_if.is_equal);
          mismatch_cnt++;
        end
        if (res_if.is_greater !== want.gt) begin
          $error("is_greater: expected %0b, got %0b", want.gt, res_if.is_greater);
          mismatch_cnt++;
        end
        if (res_if.is_less !== want.lt) begin
          $error("is_less: expected %0b, got %0b", want.lt, res_if.is_less);
          mismatch_cnt++;
        end
        if (res_if.left_infinite !== want.inf) begin
          $error("left_infinite: expected %0b, got %0b", want.inf, res_if.left_infinite);
          mismatch_cnt++;
        end
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[seconds_nanos_time_alu] ERROR");
      $finish;
    end
  end

endmodule

[sim.f]
hdl/snta_pkg.sv
hdl/snta_if.sv
hdl/snta_front.sv
hdl/snta_div_stage.sv
hdl/snta_back.sv
hdl/seconds_nanos_time_alu.sv
tb/sv/tb.sv
